/* sv/dqp_pkg.sv */
// Shared types and constants for the DNS question parser.
package dqp_pkg;

    localparam int MAX_PACKET  = 512;
    localparam int POS_W       = $clog2(MAX_PACKET + 1);
    localparam int HDR_LEN     = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  DOT_CHAR   = 8'h2E;
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [15:0] TYPE_A     = 16'h0001;
    localparam logic [15:0] CLASS_IN   = 16'h0001;
    localparam int          QR_BIT     = 15;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_QUEST  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_CLASS_BAD = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_CHARS  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  name_char;
        logic        last_of_run;
        logic [15:0] message_id;
        logic [15:0] flags_word;
        logic [15:0] question_count;
        logic        response_bit;
        logic        address_query;
        logic [15:0] query_class;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

endpackage

/* sv/dqp_parser.sv */
// Per-byte DNS header and question parser with packet state.
module dqp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_byte,
    input  logic           i_eop,
    output dqp_pkg::t_step o_step
);
    import dqp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_rem, n_rem;
    logic [15:0]      r_hw [3];
    logic [15:0]      n_hw [3];
    logic [15:0]      r_tcw [2];
    logic [15:0]      n_tcw [2];
    logic [2:0]       r_tbs, n_tbs;

    logic             active;
    logic             char_v;
    logic [7:0]       char_c;
    t_result          summ;
    t_result          chr;

    assign active = (r_pos < POS_W'(MAX_PACKET));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_eop)) begin
            r_pos    <= '0;
            r_phase  <= PH_HEADER;
            r_rem    <= '0;
            r_hw[0]  <= '0;
            r_hw[1]  <= '0;
            r_hw[2]  <= '0;
            r_tcw[0] <= '0;
            r_tcw[1] <= '0;
            r_tbs    <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_hw     <= n_hw;
            r_tcw    <= n_tcw;
            r_tbs    <= n_tbs;
        end
    end

    always_comb begin
        n_pos   = active ? r_pos + POS_W'(1) : r_pos;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_hw    = r_hw;
        n_tcw   = r_tcw;
        n_tbs   = r_tbs;
        if (active) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos < POS_W'(6)) begin
                        n_hw[r_pos[2:1]] = {r_hw[r_pos[2:1]][7:0], i_byte};
                    end
                    if (r_pos == POS_W'(HDR_LEN - 1)) begin
                        n_phase = (r_hw[2] != 16'd0) ? PH_LEN : PH_DONE;
                    end
                end
                PH_LEN: begin
                    if (i_byte == ZERO_BYTE) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_rem   = i_byte;
                        n_phase = PH_CHARS;
                    end
                end
                PH_CHARS: begin
                    if (i_byte == ZERO_BYTE) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_rem = r_rem - 8'd1;
                        if (n_rem == 8'd0) begin
                            n_phase = PH_LEN;
                        end
                    end
                end
                PH_TAIL: begin
                    if (r_tbs < 3'd2) begin
                        n_tcw[0] = {r_tcw[0][7:0], i_byte};
                    end else begin
                        n_tcw[1] = {r_tcw[1][7:0], i_byte};
                    end
                    n_tbs = r_tbs + 3'd1;
                    if (n_tbs >= 3'd4) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        char_v = 1'b0;
        char_c = '0;
        if (active) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (i_byte != ZERO_BYTE && r_pos != POS_W'(HDR_LEN)) begin
                        char_v = 1'b1;
                        char_c = DOT_CHAR;
                    end
                end
                PH_CHARS: begin
                    if (i_byte != ZERO_BYTE) begin
                        char_v = 1'b1;
                        char_c = i_byte;
                    end
                end
                default: begin
                    char_v = 1'b0;
                end
            endcase
        end

        chr             = '0;
        chr.result_kind = KIND_CHAR;
        chr.name_char   = char_c;
        chr.last_of_run = !i_eop;

        summ             = '0;
        summ.result_kind = KIND_SUMMARY;
        summ.last_of_run = 1'b1;
        if (n_pos < POS_W'(HDR_LEN)) begin
            summ.status = ST_SHORT;
        end else begin
            summ.message_id     = n_hw[0];
            summ.flags_word     = n_hw[1];
            summ.question_count = n_hw[2];
            summ.response_bit   = n_hw[1][QR_BIT];
            summ.address_query  = (n_tbs >= 3'd2) && (n_tcw[0] == TYPE_A);
            summ.query_class    = (n_tbs >= 3'd4) ? n_tcw[1] : 16'd0;
            priority if (n_hw[2] == 16'd0) begin
                summ.status = ST_NO_QUEST;
            end else if (n_tbs < 3'd4) begin
                summ.status = ST_TRUNCATED;
            end else if (n_tcw[1] != CLASS_IN) begin
                summ.status = ST_CLASS_BAD;
            end else begin
                summ.status = ST_OK;
            end
        end

        o_step        = '0;
        o_step.count  = i_step ? ({1'b0, char_v} + {1'b0, i_eop}) : 2'd0;
        o_step.first  = char_v ? chr : summ;
        o_step.second = summ;
    end

endmodule

/* sv/dqp_result_queue.sv */
// Small result queue that takes up to two results per cycle and gives one.
module dqp_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dqp_pkg::t_step   i_push,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_valid,
    output dqp_pkg::t_result o_head
);
    import dqp_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_ready = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.count);
        n_rd  = r_rd + QPTR_W'(pop_ok);
        n_cnt = r_cnt + QCNT_W'(i_push.count) - QCNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.second;
        end
    end

endmodule

/* sv/dns_question_parser_top.sv */
// Top level of the DNS question parser: byte stream in, name and summary words out.
//
// Channel   Dir  tdata                                  tuser        tlast
// s_axis    in   packet_byte[7:0]                       -            end_of_packet
// m_axis    out  name_char..status, 80 bits, see ports  result_kind  last_of_run
//
// One byte is accepted per cycle while s_axis_tready is high; results are queued.
// A byte gives at most two words (a name character and a summary), so the
// output side, one word per cycle while m_axis_tready is high, sets the rate when a
// final byte also emits a character. A four-entry result queue parts the two sides.
// Reset is synchronous, active low, and returns the parser to the header phase.
// Input stalls only while the queue holds more than two words.
module dns_question_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // packet_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // name_char[7:0], message_id[23:8], flags_word[39:24], question_count[55:40],
    // response_bit[56], address_query[57], query_class[73:58], status[76:74], zero[79:77]
    output logic [79:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // result_kind[0]
    output logic        m_axis_tlast
);
    import dqp_pkg::*;

    logic    in_fire;
    t_step   step;
    t_result head;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    dqp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_fire),
        .i_byte  (s_axis_tdata),
        .i_eop   (s_axis_tlast),
        .o_step  (step)
    );

    dqp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_pop   (m_axis_tready),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {3'b000, head.status, head.query_class, head.address_query,
                           head.response_bit, head.question_count, head.flags_word,
                           head.message_id, head.name_char};
    assign m_axis_tuser = head.result_kind;
    assign m_axis_tlast = head.last_of_run;

endmodule

/* sv/dqp_checker.sv */
// Port-level checks for the DNS question parser, bound to the top level.
module dqp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import dqp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped under stall");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_SUMMARY |-> m_axis_tlast)
        else $error("summary without last flag");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_CHAR |-> m_axis_tdata[79:8] == '0)
        else $error("name character carries summary fields");

    a_qr_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_SUMMARY |-> m_axis_tdata[56] == m_axis_tdata[39])
        else $error("response bit differs from flags word");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_SUMMARY && m_axis_tdata[76:74] == ST_SHORT
        |-> m_axis_tdata[73:0] == '0)
        else $error("short packet summary carries fields");

endmodule

bind dns_question_parser_top dqp_checker u_dqp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
